// File: rtl/sector_disk_controller_core_defines.svh
// Assertion helpers for the sector disk controller.
`ifndef SECTOR_DISK_CONTROLLER_CORE_DEFINES_SVH
`define SECTOR_DISK_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdc check failed");
`define SDC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sdc check failed");
`else
`define SDC_ASSERT(lbl, prop)
`define SDC_ASSERT_NR(lbl, prop)
`endif

`endif

// File: rtl/sdc_pkg.sv
package sdc_pkg;

  localparam int SECTOR_BYTES      = 512;
  localparam int DRIVE_COUNT       = 4;
  localparam int SECTORS_PER_DRIVE = 256;

  localparam int SEC_W     = $clog2(SECTOR_BYTES);
  localparam int DRV_W     = $clog2(DRIVE_COUNT);
  localparam int SPD_W     = $clog2(SECTORS_PER_DRIVE);
  localparam int BUF_AW    = DRV_W + SEC_W;
  localparam int MED_AW    = DRV_W + SPD_W + SEC_W;
  localparam int BUF_DEPTH = 1 << BUF_AW;
  localparam int MED_DEPTH = 1 << MED_AW;

  localparam logic [31:0] ST_BUSY  = 32'h1;
  localparam logic [31:0] ST_ERROR = 32'h2;

  localparam logic [7:0] CMD_CLR_BUSY   = 8'h00;
  localparam logic [7:0] CMD_CLR_STATUS = 8'h01;
  localparam logic [7:0] CMD_READ       = 8'h02;
  localparam logic [7:0] CMD_MREAD      = 8'h03;
  localparam logic [7:0] CMD_WRITE      = 8'h04;
  localparam logic [7:0] CMD_MWRITE     = 8'h05;
  localparam logic [7:0] CMD_PUSH       = 8'h08;
  localparam logic [7:0] CMD_FORMAT     = 8'h10;

  localparam logic [3:0] REG_STATUS  = 4'd0;
  localparam logic [3:0] REG_CMD     = 4'd1;
  localparam logic [3:0] REG_ADDR    = 4'd2;
  localparam logic [3:0] REG_ADDR_HI = 4'd3;
  localparam logic [3:0] REG_COUNT   = 4'd5;
  localparam logic [3:0] REG_DRIVE   = 4'd6;
  localparam logic [3:0] REG_STATUS2 = 4'd7;
  localparam logic [3:0] REG_DOUT    = 4'd10;
  localparam logic [3:0] REG_DIN     = 4'd11;
  localparam logic [3:0] REG_POS     = 4'd12;

  localparam logic [1:0] IC_WR_DWORD = 2'd0;
  localparam logic [1:0] IC_WR_BYTE  = 2'd1;
  localparam logic [1:0] IC_RD_DWORD = 2'd2;
  localparam logic [1:0] IC_RD_BYTE  = 2'd3;

  localparam logic CFG_MEDIA = 1'b0;
  localparam logic CFG_RO    = 1'b1;

  typedef enum logic [1:0] {MODE_NONE, MODE_READ, MODE_WRITE} mode_t;

  typedef enum logic [2:0] {
    OP_WRITE, OP_RD_STATUS, OP_RD_DWORD, OP_RD_POS, OP_RD_NONE, OP_RD_BYTE
  } op_t;

  typedef enum logic [2:0] {
    BS_CLEAR, BS_IDLE, BS_EXEC, BS_RDBUF, BS_PUSH, BS_COPY, BS_DONE
  } bstate_t;

  typedef enum logic [1:0] {CK_BUF_ZERO, CK_BUF_MED, CK_MED_BUF, CK_MED_ZERO} copy_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  reg_idx;
    logic        byte_wr;
    logic [31:0] data;
  } item_t;

endpackage

// File: rtl/sdc_front.sv
module sdc_front import sdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic        clearing,
  output logic        fq_valid,
  output item_t       fq_item,
  input  logic        fq_pop
);

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push_ok, pop_ok;

  always_comb begin
    cls.reg_idx = in_reg_index;
    cls.data    = in_write_data;
    cls.byte_wr = (in_command == IC_WR_BYTE);
    case (in_command)
      IC_WR_DWORD, IC_WR_BYTE: cls.op = OP_WRITE;
      IC_RD_DWORD: begin
        case (in_reg_index)
          REG_STATUS: cls.op = OP_RD_STATUS;
          REG_DOUT:   cls.op = OP_RD_DWORD;
          REG_POS:    cls.op = OP_RD_POS;
          default:    cls.op = OP_RD_NONE;
        endcase
      end
      IC_RD_BYTE: cls.op = OP_RD_BYTE;
      default:    cls.op = OP_RD_NONE;
    endcase
  end

  assign in_full  = (cnt_r == 2'd2) || clearing;
  assign push_ok  = in_push && !in_full;
  assign fq_valid = (cnt_r != 2'd0);
  assign pop_ok   = fq_pop && fq_valid;
  assign fq_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
  end

endmodule

// File: rtl/sdc_outq.sv
module sdc_outq import sdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        oq_push,
  input  logic [31:0] oq_data,
  output logic        oq_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_read_data
);

  logic [31:0] q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        pop_ok, push_ok;

  assign oq_full       = (cnt_r == 2'd2);
  assign out_empty     = (cnt_r == 2'd0);
  assign push_ok       = oq_push && !oq_full;
  assign pop_ok        = out_pop && !out_empty;
  assign out_read_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= oq_data;
  end

endmodule

// File: rtl/sdc_back.sv
`include "sector_disk_controller_core_defines.svh"
module sdc_back import sdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [DRIVE_COUNT-1:0] media_mask,
  input  logic [DRIVE_COUNT-1:0] ro_mask,
  input  logic                   fq_valid,
  input  item_t                  fq_item,
  output logic                   fq_pop,
  input  logic                   oq_full,
  output logic                   oq_push,
  output logic [31:0]            oq_data,
  output logic                   clearing
);

  bstate_t          state_r, state_nxt;
  logic [MED_AW-1:0] clr_r;
  item_t            cur_r;
  logic [DRV_W-1:0] active_r;

  logic [31:0] stat_r [DRIVE_COUNT];
  mode_t       mode_r [DRIVE_COUNT];
  logic [31:0] addr_r [DRIVE_COUNT];
  logic [31:0] left_r [DRIVE_COUNT];
  logic [31:0] din_r  [DRIVE_COUNT];
  logic [31:0] pos_r  [DRIVE_COUNT];

  copy_t            ck_r;
  logic [SPD_W-1:0] csec_r;
  logic [SEC_W:0]   cnt_r;
  logic [SPD_W:0]   fmt_n_r;
  logic             job_r;
  logic [2:0]       k_r, rd_len_r;
  logic [31:0]      off_r, res_r;
  logic             rok_r;

  logic [7:0] buf_mem [BUF_DEPTH];
  logic [7:0] med_mem [MED_DEPTH];
  logic [7:0] buf_q_r, med_q_r;
  logic              buf_we, med_we;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [MED_AW-1:0] med_waddr, med_raddr;
  logic [7:0]        buf_wdata, med_wdata, push_byte;

  // per-item decisions
  logic [DRV_W-1:0] d;
  logic             present, ro, in_cap, flush_ok, push_ok, copy_more;
  logic [31:0]      wval, nad, take_pos, push_pos, span;
  logic [SPD_W:0]   fmt_cnt;
  logic             fmt_ok;
  logic [32:0]      rd_p;
  logic             rd_in;
  logic [SEC_W-1:0] wi;

  logic [31:0]      x_st, x_ad, x_lf, x_dn, x_ps, x_res;
  mode_t            x_md;
  logic [DRV_W-1:0] x_act;
  logic             x_rd, x_push, x_job;
  logic [2:0]       x_len;
  copy_t            x_ck;
  logic [SPD_W-1:0] x_csec;
  logic [SPD_W:0]   x_fmt_n;

  assign d        = active_r;
  assign present  = media_mask[d];
  assign ro       = ro_mask[d];
  assign in_cap   = addr_r[d] < 32'(SECTORS_PER_DRIVE);
  assign flush_ok = present && !ro && in_cap;
  assign wval     = cur_r.byte_wr ? {24'h0, cur_r.data[7:0]} : cur_r.data;
  assign nad      = addr_r[d] + 32'd1;
  assign take_pos = pos_r[d] + ((cur_r.op == OP_RD_DWORD) ? 32'd4 : 32'd1);
  assign push_ok  = pos_r[d] <= 32'(SECTOR_BYTES - 4);
  assign push_pos = push_ok ? pos_r[d] + 32'd4 : pos_r[d];
  assign span     = 32'(SECTORS_PER_DRIVE) - addr_r[d];
  assign fmt_ok   = !ro && in_cap && (left_r[d] <= span);
  assign fmt_cnt  = (ro || !in_cap) ? '0 :
                    (left_r[d] < span) ? left_r[d][SPD_W:0] : span[SPD_W:0];
  assign rd_p     = {1'b0, off_r} + 33'(k_r);
  assign rd_in    = rd_p < 33'(SECTOR_BYTES);
  assign wi       = cnt_r[SEC_W-1:0] - SEC_W'(1);
  assign copy_more = (ck_r == CK_BUF_ZERO && fmt_n_r != '0) ||
                     (ck_r == CK_MED_ZERO && fmt_n_r > (SPD_W+1)'(1));

  always_comb begin
    x_st = stat_r[d]; x_md = mode_r[d]; x_ad = addr_r[d]; x_lf = left_r[d];
    x_dn = din_r[d];  x_ps = pos_r[d];  x_act = active_r; x_res = '0;
    x_rd = 1'b0; x_len = 3'd4; x_push = 1'b0; x_job = 1'b0; x_ck = CK_BUF_ZERO;
    x_csec = addr_r[d][SPD_W-1:0]; x_fmt_n = '0;
    case (cur_r.op)
      OP_WRITE: begin
        case (cur_r.reg_idx)
          REG_STATUS, REG_STATUS2: x_st = wval;
          REG_CMD: begin
            if (wval[7:0] == CMD_MREAD) x_md = MODE_READ;
            else if (wval[7:0] == CMD_MWRITE) x_md = MODE_WRITE;
            else if (wval[7:0] != CMD_PUSH) x_md = MODE_NONE;
            case (wval[7:0])
              CMD_CLR_BUSY:   x_st = stat_r[d] & ~ST_BUSY;
              CMD_CLR_STATUS: x_st = '0;
              CMD_READ, CMD_MREAD: begin
                x_ps = '0;
                if (present && (wval[7:0] == CMD_READ || left_r[d] != '0)) begin
                  x_st  = '0;
                  x_job = 1'b1;
                  x_ck  = in_cap ? CK_BUF_MED : CK_BUF_ZERO;
                end else begin
                  x_st = ST_ERROR;
                end
              end
              CMD_WRITE: begin
                x_st  = flush_ok ? '0 : ST_ERROR;
                x_job = flush_ok;
                x_ck  = CK_MED_BUF;
              end
              CMD_MWRITE: begin
                x_ps = '0;
                x_st = (present && left_r[d] != '0) ? ST_BUSY : ST_ERROR;
              end
              CMD_PUSH: begin
                x_push = push_ok;
                x_ps   = push_pos;
                x_st   = '0;
                if (mode_r[d] == MODE_WRITE && push_pos >= 32'(SECTOR_BYTES)) begin
                  if (!flush_ok) begin
                    x_st = ST_ERROR;
                  end else begin
                    x_job = 1'b1;
                    x_ck  = CK_MED_BUF;
                    if (left_r[d] > 32'd1) begin
                      x_lf = left_r[d] - 32'd1;
                      x_ad = nad;
                      x_ps = '0;
                      x_st = ST_BUSY;
                    end
                  end
                end
              end
              CMD_FORMAT: begin
                if (!present || left_r[d] == '0) begin
                  x_st = ST_ERROR;
                end else begin
                  x_job   = 1'b1;
                  x_fmt_n = fmt_cnt;
                  x_st    = fmt_ok ? '0 : ST_ERROR;
                end
              end
              default: x_st = ST_ERROR;
            endcase
          end
          REG_ADDR:    x_ad = cur_r.byte_wr ? {addr_r[d][31:8], cur_r.data[7:0]} : cur_r.data;
          REG_ADDR_HI: x_ad = cur_r.byte_wr ?
                              {addr_r[d][31:24], cur_r.data[7:0], addr_r[d][15:0]} : cur_r.data;
          REG_COUNT:   x_lf = wval;
          REG_DRIVE:   if (wval < 32'(DRIVE_COUNT)) x_act = wval[DRV_W-1:0];
          REG_DIN:     x_dn = cur_r.byte_wr ? {din_r[d][31:8], cur_r.data[7:0]} : cur_r.data;
          REG_POS:     x_ps = cur_r.byte_wr ? {pos_r[d][31:8], cur_r.data[7:0]} : cur_r.data;
          default: ;
        endcase
      end
      OP_RD_STATUS: x_res = stat_r[d];
      OP_RD_POS:    x_res = pos_r[d];
      OP_RD_DWORD, OP_RD_BYTE: begin
        x_rd  = 1'b1;
        x_len = (cur_r.op == OP_RD_DWORD) ? 3'd4 : 3'd1;
        x_ps  = take_pos;
        if (mode_r[d] == MODE_READ && take_pos >= 32'(SECTOR_BYTES)) begin
          if (left_r[d] > 32'd1) begin
            x_lf   = left_r[d] - 32'd1;
            x_ad   = nad;
            x_ps   = '0;
            x_job  = 1'b1;
            x_ck   = (present && nad < 32'(SECTORS_PER_DRIVE)) ? CK_BUF_MED : CK_BUF_ZERO;
            x_csec = nad[SPD_W-1:0];
          end else begin
            x_st = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_CLEAR: if (clr_r == '1) state_nxt = BS_IDLE;
      BS_IDLE:  if (fq_valid) state_nxt = BS_EXEC;
      BS_EXEC: begin
        if (x_rd) state_nxt = BS_RDBUF;
        else if (x_push) state_nxt = BS_PUSH;
        else if (x_job) state_nxt = BS_COPY;
        else state_nxt = BS_DONE;
      end
      BS_RDBUF: if (k_r == rd_len_r) state_nxt = job_r ? BS_COPY : BS_DONE;
      BS_PUSH:  if (k_r == 3'd3) state_nxt = job_r ? BS_COPY : BS_DONE;
      BS_COPY:  if (cnt_r == (SEC_W+1)'(SECTOR_BYTES) && !copy_more) state_nxt = BS_DONE;
      BS_DONE:  if (!oq_full) state_nxt = BS_IDLE;
      default:  state_nxt = BS_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    fq_pop   = (state_r == BS_IDLE) && fq_valid;
    oq_push  = (state_r == BS_DONE) && !oq_full;
    oq_data  = res_r;
    clearing = (state_r == BS_CLEAR);
  end

  always_comb begin
    case (k_r[1:0])
      2'd0:    push_byte = din_r[d][31:24];
      2'd1:    push_byte = din_r[d][23:16];
      2'd2:    push_byte = din_r[d][15:8];
      default: push_byte = din_r[d][7:0];
    endcase
  end

  // memory ports
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = {d, wi};
    buf_wdata = 8'h00;
    buf_raddr = {d, cnt_r[SEC_W-1:0]};
    med_we    = 1'b0;
    med_waddr = {d, csec_r, wi};
    med_wdata = 8'h00;
    med_raddr = {d, csec_r, cnt_r[SEC_W-1:0]};
    case (state_r)
      BS_CLEAR: begin
        buf_we    = 1'b1;
        buf_waddr = clr_r[BUF_AW-1:0];
        med_we    = 1'b1;
        med_waddr = clr_r;
      end
      BS_RDBUF: buf_raddr = {d, rd_p[SEC_W-1:0]};
      BS_PUSH: begin
        buf_we    = 1'b1;
        buf_waddr = {d, off_r[SEC_W-1:0] + SEC_W'(k_r)};
        buf_wdata = push_byte;
      end
      BS_COPY: begin
        case (ck_r)
          CK_BUF_ZERO: buf_we = (cnt_r != '0);
          CK_BUF_MED: begin
            buf_we    = (cnt_r != '0);
            buf_wdata = med_q_r;
          end
          CK_MED_BUF: begin
            med_we    = (cnt_r != '0);
            med_wdata = buf_q_r;
          end
          default: med_we = (cnt_r != '0);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_q_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (med_we) med_mem[med_waddr] <= med_wdata;
    med_q_r <= med_mem[med_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_CLEAR;
      clr_r    <= '0;
      active_r <= '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        stat_r[i] <= '0;
        mode_r[i] <= MODE_NONE;
        addr_r[i] <= '0;
        left_r[i] <= '0;
        din_r[i]  <= '0;
        pos_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == BS_CLEAR) clr_r <= clr_r + MED_AW'(1);
      if (state_r == BS_EXEC) begin
        stat_r[d] <= x_st;
        mode_r[d] <= x_md;
        addr_r[d] <= x_ad;
        left_r[d] <= x_lf;
        din_r[d]  <= x_dn;
        pos_r[d]  <= x_ps;
        active_r  <= x_act;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: if (fq_valid) cur_r <= fq_item;
      BS_EXEC: begin
        ck_r     <= x_ck;
        csec_r   <= x_csec;
        cnt_r    <= '0;
        fmt_n_r  <= x_fmt_n;
        job_r    <= x_job;
        k_r      <= '0;
        rd_len_r <= x_len;
        off_r    <= pos_r[d];
        res_r    <= x_res;
      end
      BS_RDBUF: begin
        k_r   <= k_r + 3'd1;
        rok_r <= rd_in;
        if (k_r != '0) res_r <= {res_r[23:0], rok_r ? buf_q_r : 8'h00};
      end
      BS_PUSH: k_r <= k_r + 3'd1;
      BS_COPY: begin
        if (cnt_r == (SEC_W+1)'(SECTOR_BYTES)) begin
          cnt_r <= '0;
          // buffer zeroed: move on to writing the formatted sectors
          if (ck_r == CK_BUF_ZERO) begin
            ck_r <= CK_MED_ZERO;
          end else begin
            fmt_n_r <= fmt_n_r - (SPD_W+1)'(1);
            csec_r  <= csec_r + SPD_W'(1);
          end
        end else begin
          cnt_r <= cnt_r + (SEC_W+1)'(1);
        end
      end
      default: ;
    endcase
  end

  `SDC_ASSERT(a_copy_bound, state_r == BS_COPY |-> cnt_r <= (SEC_W+1)'(SECTOR_BYTES))
  `SDC_ASSERT(a_pop_exec, fq_pop |=> state_r == BS_EXEC)
  `SDC_ASSERT(a_fmt_count, (state_r == BS_COPY && ck_r == CK_MED_ZERO) |-> fmt_n_r != '0)
  `SDC_ASSERT_NR(a_reset_clear, !rst_n |=> state_r == BS_CLEAR)

endmodule

// File: rtl/sector_disk_controller_core.sv
// Sector disk controller, four drives behind a register window.
// Input queue: drive in_command/in_reg_index/in_write_data with in_push;
// the word is taken on a clock edge where in_full is low. Every word gives
// exactly one result word (read data, zero for writes) on the output queue:
// out_read_data is valid while out_empty is low and is taken with out_pop.
// cfg_we/cfg_index/cfg_wdata write the media-present and read-only masks.
// Items run one at a time. Sector loads, flushes and the zero fill of
// format move one byte per cycle through the buffer and medium RAM ports.
// A two-word queue on each side decouples the host. After reset the medium
// and sector buffers are cleared, one byte per cycle; in_full stays high
// meanwhile. If the receiver stalls, results pile up in the output queue
// and the engine then waits on it, after which in_full rises once the
// input queue is full.
module sector_disk_controller_core import sdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_read_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);

  logic [DRIVE_COUNT-1:0] media_r, ro_r;
  logic        fq_valid, fq_pop, oq_full, oq_push, clearing;
  item_t       fq_item;
  logic [31:0] oq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_r <= '0;
      ro_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MEDIA) media_r <= cfg_wdata[DRIVE_COUNT-1:0];
      if (cfg_index == CFG_RO) ro_r <= cfg_wdata[DRIVE_COUNT-1:0];
    end
  end

  sdc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_command, .in_reg_index, .in_write_data,
    .clearing, .fq_valid, .fq_item, .fq_pop
  );

  sdc_back u_back (
    .clk, .rst_n, .media_mask(media_r), .ro_mask(ro_r), .fq_valid, .fq_item,
    .fq_pop, .oq_full, .oq_push, .oq_data, .clearing
  );

  sdc_outq u_outq (
    .clk, .rst_n, .oq_push, .oq_data, .oq_full, .out_empty, .out_pop, .out_read_data
  );

endmodule
